### design/scp_pkg.sv
// Shared types and constants for the segment closest-point block.
// Used by the top level, the port checker and the testbench.
`default_nettype none

package scp_pkg;

  localparam int CoordW = 32;
  localparam int FracBitsDef = 16;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegStartX = 3'd0,
    RegStartY = 3'd1,
    RegStartZ = 3'd2,
    RegEndX   = 3'd3,
    RegEndY   = 3'd4,
    RegEndZ   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     clamp_to_segment;
  } scp_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] param_t;
    logic signed [CoordW-1:0] closest_x;
    logic signed [CoordW-1:0] closest_y;
    logic signed [CoordW-1:0] closest_z;
    logic                     degenerate;
    logic                     saturated;
  } scp_out_t;

endpackage

`default_nettype wire

### design/segment_closest_point.sv
// Closest point on a configured 3D line or segment, fully pipelined.
// Depends on scp_pkg for payload types and register codes, and on scp_div.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid_i/in_stall_o | scp_in_t  (point, clamp)
//   out     | output    | out_valid_o/out_stall_i | scp_out_t (t, point, flags)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | index and 32-bit data
//
// One transaction enters per cycle unless in_stall_o is high; a result
// passes stages 1 to 4, the divider, which resolves one quotient bit per
// stage, and stages T, M and C on its way to the output register.
// Reset clears the segment registers and all valid bits.
// An output register plus a skid register absorb a stall; in_stall_o rises
// only when the skid register is full, so nothing is dropped or repeated.
`default_nettype none

module segment_closest_point
  import scp_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire scp_in_t            in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output scp_out_t                out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CoordW-1:0]  cfg_data_i
);

  localparam int W    = CoordW;
  localparam int DW   = 2 * W + 3;
  localparam int QW   = W + 1;
  localparam int NW   = DW + FRAC_BITS;
  localparam int CMPW = NW + QW;
  localparam int PW   = 2 * W + 1;

  typedef struct packed {
    logic [2:0][W-1:0] s;
    logic [2:0][W:0]   d;
    logic              clamp;
    logic              neg;
    logic              degen;
    logic              big;
  } side_t;

  // Segment registers.
  logic [2:0][W-1:0] start_q, end_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegStartX: start_q[0] <= cfg_data_i;
        RegStartY: start_q[1] <= cfg_data_i;
        RegStartZ: start_q[2] <= cfg_data_i;
        RegEndX:   end_q[0]   <= cfg_data_i;
        RegEndY:   end_q[1]   <= cfg_data_i;
        RegEndZ:   end_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_q;
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // Stage 1: differences D = E - S and Q = P - S.
  logic              v1_q, clamp1_q, degen1_q;
  logic [2:0][W-1:0] s1_q;
  logic [2:0][W:0]   d1_q, q1_q;
  logic [2:0][W:0]   d1_d, q1_d;
  logic [2:0][W-1:0] pt;

  assign pt = {in_data_i.point_z, in_data_i.point_y, in_data_i.point_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_d[i] = {end_q[i][W-1], end_q[i]} - {start_q[i][W-1], start_q[i]};
      q1_d[i] = {pt[i][W-1], pt[i]} - {start_q[i][W-1], start_q[i]};
    end
  end

  // Stage 2: products.
  logic              v2_q, clamp2_q, degen2_q;
  logic [2:0][W-1:0] s2_q;
  logic [2:0][W:0]   d2_q;
  logic [2:0][2*W+1:0] dd2_q, dq2_q;

  // Stage 3: dot products and sign.
  logic              v3_q, clamp3_q, degen3_q, neg3_q;
  logic [2:0][W-1:0] s3_q;
  logic [2:0][W:0]   d3_q;
  logic [DW-1:0]     dd3_q, num3_q;
  logic [DW-1:0]     dd_sum, dq_sum;

  always_comb begin
    dd_sum = '0;
    dq_sum = '0;
    for (int i = 0; i < 3; i++) begin
      dd_sum = dd_sum + DW'($signed(dd2_q[i]));
      dq_sum = dq_sum + DW'($signed(dq2_q[i]));
    end
  end

  // Stage 4: range check on the quotient and divider setup.
  logic          v4_q;
  side_t         side4_q;
  logic [DW-1:0] r4_q, dd4_q;
  logic [QW-1:0] n4_q;
  logic [NW-1:0] nval;
  logic          big;

  assign nval = {num3_q, {FRAC_BITS{1'b0}}};
  // A quotient of 2^(W+1) or more is out of range whatever the clamp says.
  assign big  = {{QW{1'b0}}, nval} >= {{FRAC_BITS{1'b0}}, dd3_q, {QW{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= start_q;
      d1_q     <= d1_d;
      q1_q     <= q1_d;
      clamp1_q <= in_data_i.clamp_to_segment;
      degen1_q <= (end_q == start_q);

      s2_q     <= s1_q;
      d2_q     <= d1_q;
      clamp2_q <= clamp1_q;
      degen2_q <= degen1_q;
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= $signed(d1_q[i]) * $signed(d1_q[i]);
        dq2_q[i] <= $signed(d1_q[i]) * $signed(q1_q[i]);
      end

      s3_q     <= s2_q;
      d3_q     <= d2_q;
      clamp3_q <= clamp2_q;
      degen3_q <= degen2_q;
      dd3_q    <= dd_sum;
      neg3_q   <= dq_sum[DW-1];
      num3_q   <= dq_sum[DW-1] ? DW'(-dq_sum) : dq_sum;

      side4_q.s     <= s3_q;
      side4_q.d     <= d3_q;
      side4_q.clamp <= clamp3_q;
      side4_q.neg   <= neg3_q;
      side4_q.degen <= degen3_q;
      side4_q.big   <= big;
      r4_q          <= DW'(nval[NW-1:QW]);
      n4_q          <= nval[QW-1:0];
      dd4_q         <= dd3_q;
    end
  end

  logic          vdiv;
  logic [QW-1:0] quo;
  side_t         sdiv;

  scp_div #(
    .DW    (DW),
    .QW    (QW),
    .SIDE_W($bits(side_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v4_q),
    .rem_i  (r4_q),
    .dvd_i  (n4_q),
    .dvs_i  (dd4_q),
    .side_i (side4_q),
    .valid_o(vdiv),
    .quo_o  (quo),
    .side_o (sdiv)
  );

  // Stage T: clamp or saturate the parameter.
  localparam logic [W-1:0] TOne = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] TMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] TMin = {1'b1, {(W-1){1'b0}}};

  logic              v5_q, sat5_q, degen5_q;
  logic [W-1:0]      t5_q;
  logic [2:0][W-1:0] s5_q;
  logic [2:0][W:0]   d5_q;
  logic [W-1:0]      t_d;
  logic              sat_t, ovf;

  assign ovf = sdiv.big || (quo[W] && (|quo[W-1:0]));

  always_comb begin
    sat_t = 1'b0;
    if (sdiv.clamp) begin
      if (sdiv.neg) begin
        t_d = '0;
      end else if (ovf || quo > QW'(TOne)) begin
        t_d = TOne;
      end else begin
        t_d = quo[W-1:0];
      end
    end else if (!sdiv.neg) begin
      if (ovf || quo[W] || quo[W-1]) begin
        t_d   = TMax;
        sat_t = 1'b1;
      end else begin
        t_d = quo[W-1:0];
      end
    end else begin
      if (ovf || quo[W] || (quo[W-1] && (|quo[W-2:0]))) begin
        t_d   = TMin;
        sat_t = 1'b1;
      end else begin
        t_d = -quo[W-1:0];
      end
    end
  end

  // Stage M: D * t per axis.
  logic              v6_q, sat6_q, degen6_q;
  logic [W-1:0]      t6_q;
  logic [2:0][W-1:0] s6_q;
  logic [2:0][PW-1:0] prod6_q;

  // Stage C: S + floor(D*t / 2^F), saturated.
  logic              p_v_q;
  scp_out_t          p_q, p_d;
  logic [2:0][W-1:0] c_d;
  logic [2:0]        csat;
  logic [PW-1:0]     sh;
  logic [PW:0]       sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh      = PW'($signed(prod6_q[i]) >>> FRAC_BITS);
      sum     = {sh[PW-1], sh} + (PW + 1)'($signed(s6_q[i]));
      csat[i] = !((&sum[PW:W-1]) || !(|sum[PW:W-1]));
      if (csat[i]) begin
        c_d[i] = sum[PW] ? TMin : TMax;
      end else begin
        c_d[i] = sum[W-1:0];
      end
    end
    if (degen6_q) begin
      p_d.param_t    = '0;
      p_d.closest_x  = s6_q[0];
      p_d.closest_y  = s6_q[1];
      p_d.closest_z  = s6_q[2];
      p_d.degenerate = 1'b1;
      p_d.saturated  = 1'b0;
    end else begin
      p_d.param_t    = t6_q;
      p_d.closest_x  = c_d[0];
      p_d.closest_y  = c_d[1];
      p_d.closest_z  = c_d[2];
      p_d.degenerate = 1'b0;
      p_d.saturated  = sat6_q || (|csat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      p_v_q <= 1'b0;
    end else if (en) begin
      v5_q  <= vdiv;
      v6_q  <= v5_q;
      p_v_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t5_q     <= t_d;
      sat5_q   <= sat_t;
      degen5_q <= sdiv.degen;
      s5_q     <= sdiv.s;
      d5_q     <= sdiv.d;

      t6_q     <= t5_q;
      sat6_q   <= sat5_q;
      degen6_q <= degen5_q;
      s6_q     <= s5_q;
      for (int i = 0; i < 3; i++) begin
        prod6_q[i] <= $signed(d5_q[i]) * $signed(t5_q);
      end

      p_q <= p_d;
    end
  end

  // Output register with a skid register behind it.
  logic     out_v_q;
  scp_out_t out_q, skid_q;
  logic     out_free;

  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || (en && p_v_q);
      skid_v_q <= 1'b0;
    end else if (en && p_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : p_q;
    end else if (en && p_v_q) begin
      skid_q <= p_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### design/scp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a sideband word alongside each transaction; no package content needed.
`default_nettype none

module scp_div #(
  parameter int DW     = 67,
  parameter int QW     = 33,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DW-1:0]     rem_i,
  input  wire logic [QW-1:0]     dvd_i,
  input  wire logic [DW-1:0]     dvs_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [QW-1:0]          quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              v_q   [QW];
  logic [DW-1:0]     r_q   [QW];
  logic [QW-1:0]     n_q   [QW];
  logic [QW-1:0]     quo_q [QW];
  logic [DW-1:0]     dvs_q [QW];
  logic [SIDE_W-1:0] side_q[QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              vin;
    logic [DW-1:0]     rin;
    logic [QW-1:0]     nin;
    logic [QW-1:0]     qin;
    logic [DW-1:0]     din;
    logic [SIDE_W-1:0] sin;
    logic [DW:0]       rs;
    logic              ge;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign rin = rem_i;
      assign nin = dvd_i;
      assign qin = '0;
      assign din = dvs_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign rin = r_q[k-1];
      assign nin = n_q[k-1];
      assign qin = quo_q[k-1];
      assign din = dvs_q[k-1];
      assign sin = side_q[k-1];
    end

    // Bring down the next dividend bit and try one subtraction.
    assign rs = {rin, nin[QW-1]};
    assign ge = rs >= {1'b0, din};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? DW'(rs - {1'b0, din}) : rs[DW-1:0];
        n_q[k]    <= {nin[QW-2:0], 1'b0};
        quo_q[k]  <= {qin[QW-2:0], ge};
        dvs_q[k]  <= din;
        side_q[k] <= sin;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

### design/scp_check.sv
// Port-level checker for segment_closest_point, attached by the bind below.
// Depends on scp_pkg for the payload and index types.
`default_nettype none

module scp_check
  import scp_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire scp_in_t            in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire scp_out_t           out_data_o,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [CfgIdxW-1:0] cfg_index_i,
  input wire logic [CoordW-1:0]  cfg_data_i
);

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // Input back-pressure only appears once a result is already waiting.
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output register");

  // A degenerate line gives t of zero and never reports saturation.
  a_degen_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.param_t == '0 && !out_data_o.saturated)
    else $error("degenerate result carries nonzero t or saturation");

  // Without a waiting result the input side is never held off.
  a_no_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled right after an idle output");

endmodule

bind segment_closest_point scp_check u_scp_check (.*);

`default_nettype wire

### tb/segment_closest_point_tb.sv
// Self-checking testbench for segment_closest_point: directed table, then random points.
// Depends on scp_pkg and the segment_closest_point RTL; predicts every result locally.
`timescale 1ns / 100ps

module segment_closest_point_tb;
  import scp_pkg::*;

  localparam int FracBits = FracBitsDef;
  localparam int DrainCycles = 60;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] FixOne = 1 <<< FracBits;

  typedef enum int {
    SegReset, SegUnitX, SegFullSpan, SegReverse, SegTiny, SegDegen, SegSmall, SegRandom
  } seg_kind_e;

  typedef struct {
    seg_kind_e seg;
    scp_in_t   pt;
    bit        typed;
    scp_out_t  want;
  } probe_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  scp_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  scp_out_t               out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxW-1:0]     cfg_index = '0;
  logic [CoordW-1:0]      cfg_data = '0;

  logic signed [CoordW-1:0] seg_reg [6];
  scp_out_t  pending_q [$];
  int        error_count = 0;
  int        point_count = 0;
  int        result_count = 0;
  int        sat_count = 0;
  int        degen_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  probe_row_t probes [$];

  segment_closest_point DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Saturate a wide signed value to the coordinate range.
  function automatic logic signed [CoordW-1:0] clip_coord(input logic signed [127:0] v,
                                                          inout bit sat);
    if (v > 128'(CoordMax)) begin
      sat = 1'b1;
      return CoordMax;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return CoordMin;
    end
    return v[CoordW-1:0];
  endfunction

  function automatic scp_out_t project_point(input scp_in_t it);
    logic signed [127:0] sw [3];
    logic signed [127:0] dw [3];
    logic signed [127:0] qw [3];
    logic signed [127:0] dd, dq, tw, prod;
    logic [159:0] num, quo;
    scp_out_t r;
    bit sat;
    bit neg;
    sat = 1'b0;
    dd = '0;
    dq = '0;
    for (int i = 0; i < 3; i++) begin
      sw[i] = seg_reg[i];
      dw[i] = 128'(seg_reg[i+3]) - sw[i];
    end
    qw[0] = 128'(it.point_x) - sw[0];
    qw[1] = 128'(it.point_y) - sw[1];
    qw[2] = 128'(it.point_z) - sw[2];
    r = '0;
    if (dw[0] == 0 && dw[1] == 0 && dw[2] == 0) begin
      r.closest_x = seg_reg[0];
      r.closest_y = seg_reg[1];
      r.closest_z = seg_reg[2];
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      dd += dw[i] * dw[i];
      dq += dw[i] * qw[i];
    end
    neg = dq < 0;
    num = 160'(neg ? -dq : dq) << FracBits;
    quo = num / 160'(dd);
    if (it.clamp_to_segment) begin
      if (neg) tw = 0;
      else if (quo > 160'(FixOne)) tw = 128'(FixOne);
      else tw = 128'(quo);
    end else if (!neg) begin
      if (quo > 160'(CoordMax)) begin
        tw = 128'(CoordMax);
        sat = 1'b1;
      end else tw = 128'(quo);
    end else begin
      if (quo > 160'(64'd2147483648)) begin
        tw = 128'(CoordMin);
        sat = 1'b1;
      end else tw = -128'(quo);
    end
    r.param_t = tw[CoordW-1:0];
    prod = (dw[0] * tw) >>> FracBits;
    r.closest_x = clip_coord(prod + sw[0], sat);
    prod = (dw[1] * tw) >>> FracBits;
    r.closest_y = clip_coord(prod + sw[1], sat);
    prod = (dw[2] * tw) >>> FracBits;
    r.closest_z = clip_coord(prod + sw[2], sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoordW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= RegEndZ) seg_reg[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CoordW-1:0] small_coord();
    return $signed(CoordW'($urandom_range(0, 2**21 - 1))) - (2**20);
  endfunction

  task automatic load_segment(input seg_kind_e kind);
    logic signed [CoordW-1:0] v [6];
    for (int i = 0; i < 3; i++) begin
      case (kind)
        SegReset: begin
          v[i] = '0; v[i+3] = '0;
        end
        SegUnitX: begin
          v[i] = '0; v[i+3] = (i == 0) ? 2 * FixOne : '0;
        end
        SegFullSpan: begin
          v[i] = CoordMin; v[i+3] = CoordMax;
        end
        SegReverse: begin
          v[i] = CoordMax; v[i+3] = CoordMin;
        end
        SegTiny: begin
          v[i] = small_coord(); v[i+3] = v[i] + ((i == 1) ? 1 : 0);
        end
        SegDegen: begin
          v[i] = $urandom; v[i+3] = v[i];
        end
        SegSmall: begin
          v[i] = small_coord(); v[i+3] = small_coord();
        end
        default: begin
          v[i] = $urandom; v[i+3] = $urandom;
        end
      endcase
    end
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_e'(i), v[i]);
    // A write to an index outside the register map must not disturb the segment.
    write_reg(RegUnused, $urandom);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_point(input scp_in_t it, input bit typed, input scp_out_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(typed ? want : project_point(it));
    point_count++;
  endtask

  function automatic scp_in_t random_point();
    scp_in_t it;
    logic signed [CoordW-1:0] c [3];
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: c[i] = $urandom;
        1: c[i] = small_coord();
        2: c[i] = seg_reg[i] + (small_coord() >>> $urandom_range(12));
        default: begin
          case ($urandom_range(2))
            0: c[i] = CoordMin;
            1: c[i] = CoordMax;
            default: c[i] = '0;
          endcase
        end
      endcase
    end
    it.point_x = c[0];
    it.point_y = c[1];
    it.point_z = c[2];
    it.clamp_to_segment = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic probe_row_t mk_row(input seg_kind_e seg, input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z, input bit clamp,
                                        input bit typed);
    probe_row_t row;
    row.seg = seg;
    row.pt = '{point_x: x, point_y: y, point_z: z, clamp_to_segment: clamp};
    row.typed = typed;
    // A zero segment after reset is degenerate: t is zero and the point is the origin.
    row.want = '0;
    row.want.degenerate = 1'b1;
    return row;
  endfunction

  // Receiver: stall decisions change on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    scp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        error_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_data.saturated) sat_count++;
        if (out_data.degenerate) degen_count++;
        if (out_data.param_t !== want.param_t) begin
          $error("param_t expected %h actual %h", want.param_t, out_data.param_t);
          error_count++;
        end
        if (out_data.closest_x !== want.closest_x) begin
          $error("closest_x expected %h actual %h", want.closest_x, out_data.closest_x);
          error_count++;
        end
        if (out_data.closest_y !== want.closest_y) begin
          $error("closest_y expected %h actual %h", want.closest_y, out_data.closest_y);
          error_count++;
        end
        if (out_data.closest_z !== want.closest_z) begin
          $error("closest_z expected %h actual %h", want.closest_z, out_data.closest_z);
          error_count++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $error("degenerate expected %b actual %b", want.degenerate, out_data.degenerate);
          error_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, out_data.saturated);
          error_count++;
        end
      end
    end
  end

  initial begin
    seg_kind_e cur_seg;
    int idle_set [4][2];
    int drain_wait;
    for (int i = 0; i < 6; i++) seg_reg[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    probes.push_back(mk_row(SegReset, 32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1));
    probes.push_back(mk_row(SegReset, CoordMax, CoordMin, CoordMax, 1'b1, 1'b1));
    probes.push_back(mk_row(SegReset, CoordMin, CoordMax, 32'sd5, 1'b0, 1'b1));
    probes.push_back(mk_row(SegUnitX, FixOne, 32'sd5, -32'sd5, 1'b0, 1'b0));
    probes.push_back(mk_row(SegUnitX, -FixOne, 32'sd0, 32'sd0, 1'b1, 1'b0));
    probes.push_back(mk_row(SegUnitX, -FixOne, 32'sd0, 32'sd0, 1'b0, 1'b0));
    probes.push_back(mk_row(SegUnitX, 8 * FixOne, FixOne, 32'sd0, 1'b1, 1'b0));
    probes.push_back(mk_row(SegUnitX, 8 * FixOne, FixOne, 32'sd0, 1'b0, 1'b0));
    probes.push_back(mk_row(SegUnitX, CoordMax, CoordMax, CoordMax, 1'b0, 1'b0));
    probes.push_back(mk_row(SegUnitX, CoordMin, CoordMin, CoordMin, 1'b0, 1'b0));
    probes.push_back(mk_row(SegUnitX, CoordMax, CoordMin, 32'sd0, 1'b1, 1'b0));
    probes.push_back(mk_row(SegTiny, CoordMax, CoordMax, CoordMax, 1'b0, 1'b0));
    probes.push_back(mk_row(SegTiny, CoordMin, CoordMin, CoordMin, 1'b0, 1'b0));
    probes.push_back(mk_row(SegTiny, CoordMax, CoordMax, CoordMax, 1'b1, 1'b0));
    probes.push_back(mk_row(SegFullSpan, CoordMax, CoordMax, CoordMax, 1'b0, 1'b0));
    probes.push_back(mk_row(SegFullSpan, CoordMin, CoordMin, CoordMin, 1'b0, 1'b0));
    probes.push_back(mk_row(SegFullSpan, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0));
    probes.push_back(mk_row(SegReverse, CoordMin, CoordMin, CoordMin, 1'b1, 1'b0));
    probes.push_back(mk_row(SegReverse, 32'sd1, -32'sd1, 32'sd0, 1'b0, 1'b0));
    probes.push_back(mk_row(SegDegen, CoordMax, 32'sd0, CoordMin, 1'b0, 1'b0));
    probes.push_back(mk_row(SegDegen, 32'sd0, CoordMax, 32'sd0, 1'b1, 1'b0));

    cur_seg = SegReset;
    foreach (probes[i]) begin
      if (probes[i].seg != cur_seg) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        cur_seg = probes[i].seg;
        load_segment(cur_seg);
      end
      send_point(probes[i].pt, probes[i].typed, probes[i].want);
    end

    idle_set = '{'{0, 0}, '{45, 0}, '{0, 45}, '{29, 29}};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph][0];
      recv_stall_pct = idle_set[ph][1];
      for (int blk = 0; blk < 3; blk++) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        load_segment(seg_kind_e'((ph * 3 + blk) % 8));
        for (int n = 0; n < 70; n++) begin
          // Hold off the sender once so the pipeline drains completely mid-stream.
          if (ph == 1 && blk == 1 && n == 35) begin
            @(negedge clk);
            in_valid <= 1'b0;
            wait_drained();
          end
          send_point(random_point(), 1'b0, '0);
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    drain_wait = 0;
    while (drain_wait < DrainCycles) begin
      @(posedge clk);
      drain_wait++;
    end

    $display("Sent %0d points over %0d segment settings and four idle/stall mixes.",
             point_count, 12 + 6);
    $display("Checked %0d results: %0d saturated, %0d degenerate.",
             result_count, sat_count, degen_count);
    if (error_count == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
